// ----- sv/nqe_pkg.sv -----
// nqe_pkg: shared types and constants for the n-queens enumerator
`timescale 1ns / 1ps

package nqe_pkg;

    // field and mask widths fixed by the 4-bit column encoding
    localparam int COL_W   = 4;
    localparam int MASK_W  = 16;
    localparam int ROW_W   = 5;
    localparam int BOARD_W = 5;
    localparam int SOL_W   = 64;

    typedef logic [COL_W-1:0]   col_t;
    typedef logic [MASK_W-1:0]  mask_t;
    typedef logic [ROW_W-1:0]   row_t;
    typedef logic [BOARD_W-1:0] board_t;
    typedef logic [SOL_W-1:0]   sol_t;

    localparam mask_t MASK_ALL = {MASK_W{1'b1}};

    // occupancy seen by a row: columns and both diagonals, already shifted
    typedef struct packed {
        mask_t cols;
        mask_t sum;
        mask_t diff;
    } occ_t;

    // control from the sequencer to one cell
    typedef struct packed {
        logic active;
        logic resume;
    } cell_ctrl_t;

endpackage

// ----- sv/nqe_if.sv -----
// nqe_req_if, nqe_rsp_if: request and response channels
`timescale 1ns / 1ps

interface nqe_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface nqe_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] solution;
    logic        found;

    modport source (output valid, output solution, output found, input ready);
    modport sink   (input valid, input solution, input found, output ready);
endinterface

// ----- sv/nqe_cell.sv -----
// nqe_cell: one board row, holds its queen column and passes occupancy down
`timescale 1ns / 1ps

module nqe_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  nqe_pkg::cell_ctrl_t ctrl,
    input  nqe_pkg::mask_t     limit,
    input  nqe_pkg::occ_t      occ_in,
    output nqe_pkg::occ_t      occ_out,
    output logic               hit,
    output nqe_pkg::col_t      col
);
    import nqe_pkg::*;

    col_t  col_reg;
    col_t  col_next;
    col_t  sel;
    mask_t above;
    mask_t cand;
    mask_t onehot;
    occ_t  occ_reg;
    occ_t  occ_next;

    // free columns at or after the starting point
    always_comb
    begin
        above = ctrl.resume ? ((MASK_ALL << col_reg) << 1) : MASK_ALL;
        cand  = ~(occ_in.cols | occ_in.sum | occ_in.diff) & limit & above;
        hit   = |cand;
        sel   = '0;
        for (int i = MASK_W - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                sel = COL_W'(i);
            end
        end
    end

    // new column and occupancy handed to the next row
    always_comb
    begin
        col_next      = (ctrl.active && hit) ? sel : col_reg;
        onehot        = MASK_W'(1) << col_next;
        occ_next.cols = occ_in.cols | onehot;
        occ_next.sum  = (occ_in.sum | onehot) >> 1;
        occ_next.diff = (occ_in.diff | onehot) << 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            occ_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            occ_reg <= occ_next;
        end
    end

    assign occ_out = occ_reg;
    assign col     = col_reg;

endmodule

// ----- sv/n_queens_solution_enumerator.sv -----
// n_queens_solution_enumerator: backtracking n-queens search over a chain of row cells
//
//   channel  dir  handshake      word
//   req      in   valid/ready    restart
//   rsp      out  valid/ready    solution[63:0], found
//   cfg      in   cfg_wr_en      cfg_wr_data[4:0] (board size)
//
// a request is accepted in S_IDLE; in S_SEARCH the active row cell makes one
// placement try or backtrack step per cycle; then S_FINISH packs the answer.
// each row cell tests all columns of its row at once, so a step is a whole row.
// reset: board size 8, enumeration fresh; no clearing pass is needed.
// req is taken only while no search runs; a finished answer waits in the
// rsp register while the next request is already searching.
`timescale 1ns / 1ps

module n_queens_solution_enumerator #(
    parameter int MAX_BOARD = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  nqe_pkg::board_t cfg_wr_data,
    nqe_req_if.sink         req,
    nqe_rsp_if.source       rsp
);
    import nqe_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        PH_FRESH,
        PH_RUNNING,
        PH_DONE
    } phase_t;

    localparam row_t MAX_N = ROW_W'(MAX_BOARD);

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    row_t   row_reg, row_next;
    logic   resume_reg, resume_next;
    board_t board_reg, board_next;
    logic   pend_found_reg, pend_found_next;
    logic   rsp_valid_reg, rsp_valid_next;
    sol_t   rsp_solution_reg, rsp_solution_next;
    logic   rsp_found_reg, rsp_found_next;

    row_t               n_eff;
    logic [MASK_W:0]    limit_wide;
    mask_t              limit;
    sol_t               packed_sol;
    logic               any_hit;
    logic [MAX_BOARD-1:0] hit_vec;
    logic [MAX_BOARD-1:0] active_vec;
    occ_t               occ_chain [0:MAX_BOARD];
    col_t               col_vec   [0:MAX_BOARD-1];
    cell_ctrl_t         ctrl_vec  [0:MAX_BOARD-1];

    // effective board size and legal column mask
    always_comb
    begin
        n_eff      = (board_reg > MAX_N) ? MAX_N : row_t'(board_reg);
        limit_wide = ((MASK_W + 1)'(1) << n_eff) - (MASK_W + 1)'(1);
        limit      = limit_wide[MASK_W-1:0];
    end

    // row cell chain
    assign occ_chain[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_BOARD; gi++)
        begin : g_row
            assign active_vec[gi]      = (state_reg == S_SEARCH) && (row_reg == ROW_W'(gi));
            assign ctrl_vec[gi].active = active_vec[gi];
            assign ctrl_vec[gi].resume = resume_reg;

            nqe_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (ctrl_vec[gi]),
                .limit   (limit),
                .occ_in  (occ_chain[gi]),
                .occ_out (occ_chain[gi+1]),
                .hit     (hit_vec[gi]),
                .col     (col_vec[gi])
            );
        end
    endgenerate

    assign any_hit = |(hit_vec & active_vec);

    // pack placed rows into nibbles
    always_comb
    begin
        packed_sol = '0;
        for (int i = 0; i < MAX_BOARD; i++)
        begin
            if (ROW_W'(i) < n_eff)
            begin
                packed_sol[COL_W*i +: COL_W] = col_vec[i];
            end
        end
    end

    // search sequencer
    always_comb
    begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        row_next          = row_reg;
        resume_next       = resume_reg;
        board_next        = board_reg;
        pend_found_next   = pend_found_reg;
        rsp_valid_next    = rsp_valid_reg;
        rsp_solution_next = rsp_solution_reg;
        rsp_found_next    = rsp_found_reg;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.restart || (phase_reg == PH_FRESH))
                    begin
                        if (n_eff == '0)
                        begin
                            pend_found_next = 1'b0;
                            phase_next      = PH_DONE;
                            row_next        = '0;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            row_next    = '0;
                            resume_next = 1'b0;
                            state_next  = S_SEARCH;
                        end
                    end
                    else if ((phase_reg != PH_RUNNING) || (row_reg == '0) ||
                             (row_reg > n_eff))
                    begin
                        pend_found_next = 1'b0;
                        phase_next      = PH_DONE;
                        row_next        = '0;
                        state_next      = S_FINISH;
                    end
                    else
                    begin
                        // resume in the last row from its next column
                        row_next    = row_reg - row_t'(1);
                        resume_next = 1'b1;
                        state_next  = S_SEARCH;
                    end
                end
            end
            S_SEARCH:
            begin
                if (any_hit)
                begin
                    if (row_reg + row_t'(1) == n_eff)
                    begin
                        pend_found_next = 1'b1;
                        phase_next      = PH_RUNNING;
                        row_next        = n_eff;
                        state_next      = S_FINISH;
                    end
                    else
                    begin
                        row_next    = row_reg + row_t'(1);
                        resume_next = 1'b0;
                    end
                end
                else if (row_reg == '0)
                begin
                    pend_found_next = 1'b0;
                    phase_next      = PH_DONE;
                    state_next      = S_FINISH;
                end
                else
                begin
                    // backtrack into the row above
                    row_next    = row_reg - row_t'(1);
                    resume_next = 1'b1;
                end
            end
            S_FINISH:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next    = 1'b1;
                    rsp_solution_next = pend_found_reg ? packed_sol : '0;
                    rsp_found_next    = pend_found_reg;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // board size write restarts the enumeration
        if (cfg_wr_en)
        begin
            board_next = cfg_wr_data;
            phase_next = PH_FRESH;
            row_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            phase_reg        <= PH_FRESH;
            row_reg          <= '0;
            resume_reg       <= 1'b0;
            board_reg        <= BOARD_W'(8);
            pend_found_reg   <= 1'b0;
            rsp_valid_reg    <= 1'b0;
            rsp_solution_reg <= '0;
            rsp_found_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            row_reg          <= row_next;
            resume_reg       <= resume_next;
            board_reg        <= board_next;
            pend_found_reg   <= pend_found_next;
            rsp_valid_reg    <= rsp_valid_next;
            rsp_solution_reg <= rsp_solution_next;
            rsp_found_reg    <= rsp_found_next;
        end
    end

    assign req.ready    = (state_reg == S_IDLE);
    assign rsp.valid    = rsp_valid_reg;
    assign rsp.solution = rsp_solution_reg;
    assign rsp.found    = rsp_found_reg;

endmodule

// ----- sv/nqe_checker.sv -----
// nqe_checker: port-level assertions for the n-queens enumerator, with its bind
`timescale 1ns / 1ps

module nqe_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [63:0] rsp_solution,
    input logic        rsp_found
);
    logic [1:0] outstanding_reg;
    logic [1:0] outstanding_next;
    logic       req_take;
    logic       rsp_take;

    assign req_take = req_valid && req_ready;
    assign rsp_take = rsp_valid && rsp_ready;

    // words accepted but not yet answered
    always_comb
    begin
        outstanding_next = outstanding_reg;
        if (req_take && !rsp_take)
        begin
            outstanding_next = outstanding_reg + 2'd1;
        end
        else if (!req_take && rsp_take)
        begin
            outstanding_next = outstanding_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    // exhausted answer carries no solution
    a_exhausted_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_found) |-> (rsp_solution == 64'd0))
        else $error("exhausted answer with nonzero solution");

    // no answer without a request behind it
    a_rsp_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (outstanding_reg != 2'd0))
        else $error("answer without pending request");

    // at most one answer waits while a new request is taken
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        req_take |-> (outstanding_reg <= 2'd1))
        else $error("request taken with two words in flight");

    // stalled answer holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
            (rsp_valid && $stable(rsp_solution) && $stable(rsp_found)))
        else $error("stalled answer changed");

endmodule

bind n_queens_solution_enumerator nqe_checker u_nqe_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_solution (rsp.solution),
    .rsp_found    (rsp.found)
);
